// ===== sv/scqc_pkg.sv =====
// Shared types, constants and the x4 transition decode for the six-channel
// quadrature counter. No dependencies; every other file depends on this package.
`default_nettype none

package scqc_pkg;

   // Number of decoded encoders and number of count fields in a result
   localparam int unsigned NUM_MOTORS = 6;
   localparam int unsigned OUT_FIELDS = 6;

   // Field widths
   localparam int unsigned SAMPLE_W = 14;
   localparam int unsigned MOTOR_W  = 3;
   localparam int unsigned COUNT_W  = 16;

   // Bit offset of channel B within the pin word
   localparam int unsigned CHB_OFFSET = 8;

   // Item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_PRESET = 1'b1;

   // Step codes carried from the front to the back
   typedef logic [1:0] step_type;
   localparam step_type STEP_NONE = 2'b00;
   localparam step_type STEP_UP   = 2'b01;
   localparam step_type STEP_DOWN = 2'b10;

   typedef logic signed [COUNT_W-1:0] count_type;

   // One classified item in the queue
   typedef struct packed {
      logic                                 is_preset;
      logic [MOTOR_W-1:0]                   motor;
      logic signed [COUNT_W-1:0]            preset_value;
      logic [NUM_MOTORS-1:0][1:0]           steps;
   } step_item_type;

   // Decode {old B, old A, new B, new A} into a step; double changes give none
   function automatic step_type decode_step(input logic [3:0] code);
      step_type step;
      unique case (code)
         4'b0001, 4'b0111, 4'b1000, 4'b1110: step = STEP_DOWN;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: step = STEP_UP;
         default:                            step = STEP_NONE;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

// ===== sv/scqc_ifs.sv =====
// Valid/ready channel interfaces for the quadrature counter: the request
// channel (samples and presets) and the response channel (six counts).
// Depends on scqc_pkg.
`default_nettype none

interface scqc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic [scqc_pkg::SAMPLE_W-1:0]      sample;
   logic [scqc_pkg::MOTOR_W-1:0]       motor;
   logic signed [scqc_pkg::COUNT_W-1:0] preset_value;

   modport source (output valid, opcode, sample, motor, preset_value, input ready);
   modport sink   (input valid, opcode, sample, motor, preset_value, output ready);
endinterface

interface scqc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [scqc_pkg::COUNT_W-1:0] count_0;
   logic signed [scqc_pkg::COUNT_W-1:0] count_1;
   logic signed [scqc_pkg::COUNT_W-1:0] count_2;
   logic signed [scqc_pkg::COUNT_W-1:0] count_3;
   logic signed [scqc_pkg::COUNT_W-1:0] count_4;
   logic signed [scqc_pkg::COUNT_W-1:0] count_5;

   modport source (output valid, count_0, count_1, count_2, count_3, count_4, count_5,
                   input ready);
   modport sink   (input valid, count_0, count_1, count_2, count_3, count_4, count_5,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/scqc_front.sv =====
// Front end: accepts request transactions, keeps the previous pin word and
// classifies each motor's pin change into a step code. Depends on scqc_pkg.
`default_nettype none

module scqc_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   scqc_req_if.sink                     req_ch,
   output      logic                    push_valid,
   output      scqc_pkg::step_item_type push_item,
   input  wire logic                    push_ready
);
   import scqc_pkg::*;

   logic                primed_in;
   logic [SAMPLE_W-1:0] prev_sample_ff;
   logic                primed_ff;
   logic                accept;
   logic                take_sample;

   // Pass the queue's backpressure straight through
   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;
   assign take_sample  = accept && (req_ch.opcode == OP_SAMPLE);

   // Classify: build the per-motor step codes
   always_comb begin
      push_item.is_preset    = (req_ch.opcode == OP_PRESET);
      push_item.motor        = req_ch.motor;
      push_item.preset_value = req_ch.preset_value;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         if (primed_ff && (req_ch.opcode == OP_SAMPLE)) begin
            push_item.steps[m] = decode_step({prev_sample_ff[CHB_OFFSET+m],
                                              prev_sample_ff[m],
                                              req_ch.sample[CHB_OFFSET+m],
                                              req_ch.sample[m]});
         end else begin
            push_item.steps[m] = STEP_NONE;
         end
      end
   end

   assign primed_in = primed_ff || take_sample;

   // Hold the last pin word; the first sample only primes it
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff      <= 1'b0;
         prev_sample_ff <= '0;
      end else begin
         primed_ff <= primed_in;
         if (take_sample) begin
            prev_sample_ff <= req_ch.sample;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/scqc_queue.sv =====
// Two-entry queue that decouples the classifying front from the counting
// back end. Depends on scqc_pkg for the entry type.
`default_nettype none

module scqc_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  wire scqc_pkg::step_item_type push_item,
   output      logic                    push_ready,
   output      logic                    pop_valid,
   output      scqc_pkg::step_item_type pop_item,
   input  wire logic                    pop_ready
);
   import scqc_pkg::*;

   step_item_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/scqc_back.sv =====
// Back end: applies step codes and presets to the motor counters and holds
// the six counts in the response register. Depends on scqc_pkg.
`default_nettype none

module scqc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   input  wire scqc_pkg::step_item_type pop_item,
   output      logic                    pop_ready,
   scqc_rsp_if.source                   rsp_ch
);
   import scqc_pkg::*;

   count_type counter_ff [NUM_MOTORS];
   count_type counter_in [NUM_MOTORS];
   count_type rsp_count_ff [OUT_FIELDS];
   logic      rsp_valid_ff, rsp_valid_in;
   logic      do_pop;

   // Take a new item whenever the response register is free or draining
   assign pop_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign do_pop       = pop_valid && pop_ready;
   assign rsp_valid_in = do_pop || (rsp_valid_ff && !rsp_ch.ready);

   // Next counter values: preset load or wrapping step
   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         counter_in[m] = counter_ff[m];
         if (pop_item.is_preset) begin
            if (pop_item.motor == MOTOR_W'(m)) begin
               counter_in[m] = pop_item.preset_value;
            end
         end else begin
            case (pop_item.steps[m])
               STEP_UP:   counter_in[m] = counter_ff[m] + count_type'(1);
               STEP_DOWN: counter_in[m] = counter_ff[m] - count_type'(1);
               default:   counter_in[m] = counter_ff[m];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            counter_ff[m] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
               counter_ff[m] <= counter_in[m];
            end
         end
      end
   end

   // Capture the response counts; fields past the last motor stay zero
   always_ff @(posedge clock) begin
      for (int m = 0; m < OUT_FIELDS; m++) begin
         if (do_pop) begin
            if (m < NUM_MOTORS) begin
               rsp_count_ff[m] <= counter_in[m];
            end else begin
               rsp_count_ff[m] <= '0;
            end
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.count_0 = rsp_count_ff[0];
   assign rsp_ch.count_1 = rsp_count_ff[1];
   assign rsp_ch.count_2 = rsp_count_ff[2];
   assign rsp_ch.count_3 = rsp_count_ff[3];
   assign rsp_ch.count_4 = rsp_count_ff[4];
   assign rsp_ch.count_5 = rsp_count_ff[5];

endmodule

`default_nettype wire

// ===== sv/six_channel_quadrature_counter.sv =====
// Six-channel x4 quadrature counter: front classifier, queue and counter
// back end. Depends on scqc_pkg, scqc_ifs, scqc_front, scqc_queue, scqc_back.
//
// Usage:
//   req_ch carries one transaction per item: a pin sample (opcode 0, channel A
//   of motors 0-5 on sample bits 0-5, channel B on bits 8-13) or a preset
//   (opcode 1) that loads preset_value into the counter of one motor.
//   rsp_ch returns one transaction per item with all six 16-bit counts after
//   that item; counters wrap, and a change of both channels at once counts 0.
//   Path: an accepted item is written into the queue, then popped by the back end
//   into the response register once that register is free or draining.
//   Throughput: one item per cycle while the receiver takes each result; the front
//   keeps taking items while a result waits, until the queue is full.
//   Reset (synchronous, active high) clears all counters, the queue and the
//   previous pin word; the first sample after reset only primes that word.
//   When the receiver stalls, the response holds, the two-entry queue fills,
//   and req_ch.ready drops once it is full; nothing is lost or repeated.
`default_nettype none

module six_channel_quadrature_counter (
   input  wire logic  clock,
   input  wire logic  reset,
   scqc_req_if.sink   req_ch,
   scqc_rsp_if.source rsp_ch
);
   import scqc_pkg::*;

   logic          push_valid, push_ready;
   logic          pop_valid, pop_ready;
   step_item_type push_item, pop_item;

   scqc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   scqc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   scqc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the six-channel quadrature counter: random idling
// on both channels, a scoreboard that predicts all six counts for each item.
// Depends on scqc_pkg, scqc_ifs and the six_channel_quadrature_counter RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scqc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 1340;
   localparam int unsigned REPORT_MAX   = 10;

   // six counts of one response, motor 0 in slot 0
   typedef logic [OUT_FIELDS-1:0][COUNT_W-1:0] count_set_t;

   // Tracks the decoder state and queues the counts each transaction must return
   class count_scoreboard;
      logic [SAMPLE_W-1:0] last_pins;
      bit                  primed;
      count_type           counts[OUT_FIELDS];
      count_set_t          expected_q[$];
      int unsigned         mismatches;

      function new();
         last_pins  = '0;
         primed     = 1'b0;
         mismatches = 0;
         foreach (counts[m]) counts[m] = '0;
      endfunction

      // position of an A/B pair along the x4 cycle 00, 10, 11, 01 (B, A)
      function int unsigned pin_phase(input logic b, input logic a);
         return {a, a ^ b};
      endfunction

      // apply one accepted request and queue the resulting counts
      function void note_item(input logic opcode, input logic [SAMPLE_W-1:0] pins,
                              input logic [MOTOR_W-1:0] motor, input count_type value);
         int unsigned old_phase;
         int unsigned new_phase;
         int unsigned phase_step;
         count_set_t  set;
         if (opcode == OP_SAMPLE) begin
            if (primed) begin
               for (int m = 0; m < NUM_MOTORS; m++) begin
                  old_phase = pin_phase(last_pins[m + CHB_OFFSET], last_pins[m]);
                  new_phase = pin_phase(pins[m + CHB_OFFSET], pins[m]);
                  phase_step = (new_phase - old_phase) & 3;
                  // one phase ahead counts up, one behind counts down, two is illegal
                  if (phase_step == 1) counts[m] = counts[m] + 16'sd1;
                  else if (phase_step == 3) counts[m] = counts[m] - 16'sd1;
               end
            end
            last_pins = pins;
            primed    = 1'b1;
         end else if (motor < NUM_MOTORS) begin
            counts[motor] = value;
         end
         for (int m = 0; m < OUT_FIELDS; m++)
            set[m] = (m < NUM_MOTORS) ? counts[m] : '0;
         expected_q.push_back(set);
      endfunction

      // compare one response against the oldest expectation
      function void check_counts(input count_set_t got);
         count_set_t want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: response with no transaction pending, count_0=%0d",
                        $signed(got[0]));
            return;
         end
         want = expected_q.pop_front();
         for (int m = 0; m < OUT_FIELDS; m++) begin
            if (got[m] !== want[m]) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("ERROR: count_%0d expected %0d, got %0d", m,
                           $signed(want[m]), $signed(got[m]));
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   scqc_req_if req_ch ();
   scqc_rsp_if rsp_ch ();

   six_channel_quadrature_counter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   count_scoreboard board = new();

   logic [SAMPLE_W-1:0] pin_word;
   int unsigned         items_sent;
   int unsigned         results_seen;
   int unsigned         cycle_count;
   bit                  sender_busy;

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Record each accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_item(req_ch.opcode, req_ch.sample, req_ch.motor, req_ch.preset_value);
   end

   // Check each accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_counts({rsp_ch.count_5, rsp_ch.count_4, rsp_ch.count_3,
                             rsp_ch.count_2, rsp_ch.count_1, rsp_ch.count_0});
         results_seen <= results_seen + 1;
      end
   end

   // Offer one request; valid stays high into the next call when no gap is drawn
   task automatic send_item(input logic opcode, input logic [SAMPLE_W-1:0] pins,
                            input logic [MOTOR_W-1:0] motor, input count_type value);
      int unsigned gap_cycles;
      bit          burst;
      burst = (items_sent % 300) >= 200 || (items_sent >= 380 && items_sent < 700);
      gap_cycles = burst ? 0 : $urandom_range(0, 9);
      if (gap_cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= opcode;
      req_ch.sample       <= pins;
      req_ch.motor        <= motor;
      req_ch.preset_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (opcode == OP_SAMPLE) pin_word = pins;
      items_sent++;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] pins);
      send_item(OP_SAMPLE, pins, MOTOR_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic send_preset(input logic [MOTOR_W-1:0] motor, input count_type value);
      send_item(OP_PRESET, SAMPLE_W'($urandom), motor, value);
   endtask

   // Build the next pin word as a mostly legal walk: each motor steps, holds, or rarely jumps
   function automatic logic [SAMPLE_W-1:0] walk_pins(input logic [SAMPLE_W-1:0] pins);
      logic [SAMPLE_W-1:0] next_pins;
      int unsigned         phase;
      int unsigned         move;
      logic [1:0]          p;
      next_pins = pins;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         phase = {pins[m], pins[m] ^ pins[m + CHB_OFFSET]};
         move  = $urandom_range(0, 19);
         if (move < 8) phase = phase + 1;
         else if (move < 16) phase = phase + 3;
         else if (move == 19) phase = phase + 2;
         p = phase[1:0];
         next_pins[m]              = p[1];
         next_pins[m + CHB_OFFSET] = p[1] ^ p[0];
      end
      next_pins[7:6] = 2'($urandom);
      return next_pins;
   endfunction

   // Preset value biased toward the wrap points
   function automatic count_type pick_preset();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh7FFE;
         3:       return 16'sh8001;
         default: return COUNT_W'($urandom);
      endcase
   endfunction

   // Response side: random stalls, stall-free stretches and one long hold-off
   initial begin
      int unsigned hold_cycles;
      bit          held_long;
      held_long = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         hold_cycles = ((results_seen % 250) >= 180) ? 0 : $urandom_range(0, 9);
         if (!held_long && results_seen >= 400) begin
            hold_cycles = 300;
            held_long   = 1'b1;
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Reset, directed items, random items, drain
   initial begin
      int unsigned pick;
      items_sent   = 0;
      pin_word     = '0;
      reset <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_SAMPLE;
      req_ch.sample       <= '0;
      req_ch.motor        <= '0;
      req_ch.preset_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // presets before any sample, including motor indexes past the last motor
      send_preset(3'd0, 16'sh7FFF);
      send_preset(3'd1, 16'sh8000);
      send_preset(3'd6, 16'sh1234);
      send_preset(3'd7, 16'shFFFF);
      // first sample only primes; unused pin bits set
      send_sample(14'h3FFF);
      // motor 0 steps up through the top, motor 1 down through the bottom
      send_sample(14'h023D);
      // motors 0-4 change both channels at once, motor 5 changes only channel A
      send_sample(14'h1DC2);
      send_sample(14'h1DC2);
      send_preset(3'd5, 16'shFFFF);
      send_preset(3'd2, 16'sh7FFF);
      send_sample(14'h0000);
      send_sample(14'h3F3F);
      send_preset(3'd3, 16'sh0000);
      send_preset(3'd4, 16'sh8000);
      send_sample(14'h3F00);
      send_sample(14'h00FF);
      send_sample(14'h0000);

      // mostly legal walks, some noise words and presets
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) send_sample(walk_pins(pin_word));
         else if (pick < 88) send_sample(SAMPLE_W'($urandom));
         else send_preset(MOTOR_W'($urandom_range(0, 7)), pick_preset());
      end
      req_ch.valid <= 1'b0;

      // drain, then allow the pipeline latency to pass
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
